// ===== hdl/tpc_pkg.sv =====
package tpc_pkg;

    localparam int COUNTER_WIDTH = 32;
    localparam int CHANNELS      = 4;

    localparam int PSC_W        = 16;
    localparam int FLAG_W       = 5;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 4;
    localparam int CMD_W        = 2;
    localparam int PWM_W        = 4;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 40;

    localparam int CTL_EN_BIT   = 0;
    localparam int CTL_OPM_BIT  = 3;
    localparam int CTL_ARPE_BIT = 7;
    localparam int CCR_PE_BIT   = 3;
    localparam int EGR_UG_BIT   = 0;

    localparam logic [2:0] MODE_PWM1 = 3'd6;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_CTRL  = 4'd0,
        REG_SR    = 4'd1,
        REG_IER   = 4'd2,
        REG_EGR   = 4'd3,
        REG_CNT   = 4'd4,
        REG_PSC   = 4'd5,
        REG_ARR   = 4'd6,
        REG_MODE0 = 4'd7,
        REG_MODE1 = 4'd8,
        REG_CHEN  = 4'd9,
        REG_CCR0  = 4'd10
    } t_reg_idx;

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;
    typedef logic [1:0][15:0]         t_mode;
    typedef logic [CHANNELS-1:0][COUNTER_WIDTH-1:0] t_ccr;

    typedef struct packed {
        t_cmd             cmd;
        t_reg_idx         idx;
        logic [DATA_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              upd;
    } t_result;

    typedef struct packed {
        logic [7:0]        ctrl;
        logic [FLAG_W-1:0] flags;
        logic [FLAG_W-1:0] irq_en;
        t_cnt              cnt;
        t_mode             mode;
        logic [15:0]       chen;
        t_ccr              ccr_act;
    } t_view;

    function automatic logic [7:0] chan_byte(input t_mode mode, input int c);
        return mode[c[1]][((c & 1) * 8) +: 8];
    endfunction

    function automatic logic [2:0] pwm_mode(input t_mode mode, input int c);
        logic [7:0] b;
        b = chan_byte(mode, c);
        return b[6:4];
    endfunction

    function automatic logic ccr_preload(input t_mode mode, input int c);
        logic [7:0] b;
        b = chan_byte(mode, c);
        return b[CCR_PE_BIT];
    endfunction

endpackage

// ===== hdl/timer_with_pwm_compare_core.sv =====
// General-purpose up-counting timer with four PWM compare channels. Each input
// beat is a prescaler tick, a register write or a register read, and each one
// yields exactly one output beat. One beat is taken per clock while the result is
// not stalled. The input register loads at the accepting edge, and the whole register
// update for a beat is made in a single step at the edge that loads the result register,
// once the result register is free or being drained. A stalled result holds the input
// register, so at most two beats are in flight.
// irq and pwm_out reflect the timer state right after the beat they ride on.
module timer_with_pwm_compare_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] reg_index, [35:4] write_data, [39:36] zero
    input  logic [tpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [tpc_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] read_data, [32] irq, [36:33] pwm_out, [37] update_pulse, [39:38] zero
    output logic [tpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic              advance;
    logic              fire;
    tpc_pkg::t_item    item;
    tpc_pkg::t_result  result;
    tpc_pkg::t_view    view;

    tpc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_advance (advance),
        .o_fire    (fire),
        .o_item    (item)
    );

    tpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (item),
        .o_result (result),
        .o_view   (view)
    );

    tpc_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire),
        .i_result  (result),
        .i_view    (view),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_tdata   (m_axis_tdata),
        .o_advance (advance)
    );

`ifndef SYNTHESIS
    a_upd_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[37]) |-> view.flags[0])
        else $error("update beat without update flag");

    a_stopped_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && item.cmd == tpc_pkg::CMD_TICK && !view.ctrl[tpc_pkg::CTL_EN_BIT])
        |=> $stable(view.cnt))
        else $error("counter moved on a tick while disabled");

    a_stall_freezes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(view.cnt) && $stable(view.flags)))
        else $error("timer state changed under a stalled result");
`endif

endmodule

// ===== hdl/tpc_in_stage.sv =====
module tpc_in_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tpc_pkg::IN_TDATA_W-1:0]      i_tdata,
    input  logic [tpc_pkg::CMD_W-1:0]           i_tuser,
    input  logic                                i_advance,
    output logic                                o_fire,
    output tpc_pkg::t_item                      o_item
);

    logic           r_valid;
    tpc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_fire  = r_valid && i_advance;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.cmd  <= tpc_pkg::t_cmd'(i_tuser);
            r_item.idx  <= tpc_pkg::t_reg_idx'(i_tdata[tpc_pkg::IDX_W-1:0]);
            r_item.data <= i_tdata[tpc_pkg::IDX_W +: tpc_pkg::DATA_W];
        end
    end

endmodule

// ===== hdl/tpc_core.sv =====
module tpc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tpc_pkg::t_item    i_item,
    output tpc_pkg::t_result  o_result,
    output tpc_pkg::t_view    o_view
);

    localparam int CW = tpc_pkg::COUNTER_WIDTH;
    localparam int PW = tpc_pkg::PSC_W;
    localparam int FW = tpc_pkg::FLAG_W;

    logic [7:0]        r_ctrl,    n_ctrl;
    logic [FW-1:0]     r_flags,   n_flags;
    logic [FW-1:0]     r_irq_en,  n_irq_en;
    tpc_pkg::t_cnt     r_cnt,     n_cnt;
    logic [PW-1:0]     r_psc_cnt, n_psc_cnt;
    logic [PW-1:0]     r_psc_pre, n_psc_pre;
    logic [PW-1:0]     r_psc_act, n_psc_act;
    tpc_pkg::t_cnt     r_arr_pre, n_arr_pre;
    tpc_pkg::t_cnt     r_arr_act, n_arr_act;
    tpc_pkg::t_mode    r_mode,    n_mode;
    logic [15:0]       r_chen,    n_chen;
    tpc_pkg::t_ccr     r_ccr_pre, n_ccr_pre;
    tpc_pkg::t_ccr     r_ccr_act, n_ccr_act;

    logic                         load;
    logic                         upd;
    logic [tpc_pkg::DATA_W-1:0]   rd;
    logic [tpc_pkg::CHANNELS-1:0] match;
    tpc_pkg::t_cnt                cnt_inc;
    logic                         cnt_wrap;
    logic                         psc_wrap;

    assign cnt_inc  = r_cnt + CW'(1);
    assign cnt_wrap = r_cnt >= r_arr_act;
    assign psc_wrap = r_psc_cnt >= r_psc_act;

    always_comb begin
        n_ctrl    = r_ctrl;
        n_flags   = r_flags;
        n_irq_en  = r_irq_en;
        n_cnt     = r_cnt;
        n_psc_cnt = r_psc_cnt;
        n_psc_pre = r_psc_pre;
        n_psc_act = r_psc_act;
        n_arr_pre = r_arr_pre;
        n_arr_act = r_arr_act;
        n_mode    = r_mode;
        n_chen    = r_chen;
        n_ccr_pre = r_ccr_pre;
        n_ccr_act = r_ccr_act;
        load      = 1'b0;
        upd       = 1'b0;
        rd        = '0;
        match     = '0;

        if (i_fire) begin
            unique case (i_item.cmd)
                tpc_pkg::CMD_TICK: begin
                    if (r_ctrl[tpc_pkg::CTL_EN_BIT]) begin
                        if (psc_wrap) begin
                            n_psc_cnt = '0;
                            if (cnt_wrap) begin
                                n_cnt = '0;
                                load  = 1'b1;
                                upd   = 1'b1;
                                if (r_ctrl[tpc_pkg::CTL_OPM_BIT]) begin
                                    n_ctrl[tpc_pkg::CTL_EN_BIT] = 1'b0;
                                end
                            end else begin
                                n_cnt = cnt_inc;
                            end
                            // after a wrap the active compare is the preload copy
                            for (int c = 0; c < tpc_pkg::CHANNELS; c++) begin
                                match[c] = cnt_wrap ? (r_ccr_pre[c] == '0)
                                                    : (cnt_inc == r_ccr_act[c]);
                            end
                        end else begin
                            n_psc_cnt = r_psc_cnt + PW'(1);
                        end
                    end
                end
                tpc_pkg::CMD_WRITE: begin
                    unique case (i_item.idx)
                        tpc_pkg::REG_CTRL:  n_ctrl   = i_item.data[7:0];
                        tpc_pkg::REG_SR:    n_flags  = r_flags & i_item.data[FW-1:0];
                        tpc_pkg::REG_IER:   n_irq_en = i_item.data[FW-1:0];
                        tpc_pkg::REG_EGR: begin
                            if (i_item.data[tpc_pkg::EGR_UG_BIT]) begin
                                n_cnt     = '0;
                                n_psc_cnt = '0;
                                load      = 1'b1;
                                upd       = 1'b1;
                            end
                        end
                        tpc_pkg::REG_CNT:   n_cnt     = i_item.data[CW-1:0];
                        tpc_pkg::REG_PSC:   n_psc_pre = i_item.data[PW-1:0];
                        tpc_pkg::REG_ARR: begin
                            n_arr_pre = i_item.data[CW-1:0];
                            if (!r_ctrl[tpc_pkg::CTL_ARPE_BIT]) begin
                                n_arr_act = i_item.data[CW-1:0];
                            end
                        end
                        tpc_pkg::REG_MODE0: n_mode[0] = i_item.data[15:0];
                        tpc_pkg::REG_MODE1: n_mode[1] = i_item.data[15:0];
                        tpc_pkg::REG_CHEN:  n_chen    = i_item.data[15:0];
                        default: begin
                            for (int c = 0; c < tpc_pkg::CHANNELS; c++) begin
                                if (4'(i_item.idx) == 4'(tpc_pkg::REG_CCR0) + 4'(c)) begin
                                    n_ccr_pre[c] = i_item.data[CW-1:0];
                                    if (!tpc_pkg::ccr_preload(r_mode, c)) begin
                                        n_ccr_act[c] = i_item.data[CW-1:0];
                                    end
                                end
                            end
                        end
                    endcase
                end
                tpc_pkg::CMD_READ: begin
                    unique case (i_item.idx)
                        tpc_pkg::REG_CTRL:  rd = 32'(r_ctrl);
                        tpc_pkg::REG_SR:    rd = 32'(r_flags);
                        tpc_pkg::REG_IER:   rd = 32'(r_irq_en);
                        tpc_pkg::REG_CNT:   rd = 32'(r_cnt);
                        tpc_pkg::REG_PSC:   rd = 32'(r_psc_pre);
                        tpc_pkg::REG_ARR:   rd = 32'(r_arr_pre);
                        tpc_pkg::REG_MODE0: rd = 32'(r_mode[0]);
                        tpc_pkg::REG_MODE1: rd = 32'(r_mode[1]);
                        tpc_pkg::REG_CHEN:  rd = 32'(r_chen);
                        default: begin
                            for (int c = 0; c < tpc_pkg::CHANNELS; c++) begin
                                if (4'(i_item.idx) == 4'(tpc_pkg::REG_CCR0) + 4'(c)) begin
                                    rd = 32'(r_ccr_pre[c]);
                                end
                            end
                        end
                    endcase
                end
                tpc_pkg::CMD_NOP: begin
                end
            endcase
        end

        if (load) begin
            n_psc_act = r_psc_pre;
            n_arr_act = r_arr_pre;
            n_ccr_act = r_ccr_pre;
            n_flags[0] = 1'b1;
        end
        for (int c = 0; c < tpc_pkg::CHANNELS; c++) begin
            if (match[c]) begin
                n_flags[c+1] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_flags   <= '0;
            r_irq_en  <= '0;
            r_cnt     <= '0;
            r_psc_cnt <= '0;
            r_psc_pre <= '0;
            r_psc_act <= '0;
            r_arr_pre <= '1;
            r_arr_act <= '1;
            r_mode    <= '0;
            r_chen    <= '0;
            r_ccr_pre <= '0;
            r_ccr_act <= '0;
        end else begin
            r_ctrl    <= n_ctrl;
            r_flags   <= n_flags;
            r_irq_en  <= n_irq_en;
            r_cnt     <= n_cnt;
            r_psc_cnt <= n_psc_cnt;
            r_psc_pre <= n_psc_pre;
            r_psc_act <= n_psc_act;
            r_arr_pre <= n_arr_pre;
            r_arr_act <= n_arr_act;
            r_mode    <= n_mode;
            r_chen    <= n_chen;
            r_ccr_pre <= n_ccr_pre;
            r_ccr_act <= n_ccr_act;
        end
    end

    assign o_result.read_data = rd;
    assign o_result.upd       = upd;

    assign o_view.ctrl    = r_ctrl;
    assign o_view.flags   = r_flags;
    assign o_view.irq_en  = r_irq_en;
    assign o_view.cnt     = r_cnt;
    assign o_view.mode    = r_mode;
    assign o_view.chen    = r_chen;
    assign o_view.ccr_act = r_ccr_act;

endmodule

// ===== hdl/tpc_out_stage.sv =====
module tpc_out_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  tpc_pkg::t_result                  i_result,
    input  tpc_pkg::t_view                    i_view,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [tpc_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic                              o_advance
);

    logic                       r_valid;
    tpc_pkg::t_result           r_result;
    logic [tpc_pkg::PWM_W-1:0]  pwm;
    logic                       irq;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // timer state only moves together with a new result, so it matches r_result
    always_comb begin
        pwm = '0;
        for (int c = 0; c < tpc_pkg::CHANNELS; c++) begin
            pwm[c] = i_view.chen[4*c]
                  && (tpc_pkg::pwm_mode(i_view.mode, c) == tpc_pkg::MODE_PWM1)
                  && (i_view.cnt < i_view.ccr_act[c]);
        end
    end

    assign irq = |(i_view.flags & i_view.irq_en);

    assign o_tdata = {2'b00, r_result.upd, pwm, irq, r_result.read_data};

endmodule
